@@ hw/rtl/tsrt_pkg.sv @@
// Package for the two-segment rational taper core: fixed-point constants
// and register index codes. No dependencies.
`default_nettype none
package tsrt_pkg;
	localparam int FRAC_BITS = 15;
	localparam int IFR = 24;
	localparam logic [24:0] IONE = 25'd16777216;
	localparam logic [23:0] SPR_TOP = 24'd16760439;
	localparam logic [23:0] SPR_SPAN = 24'd11727274;
	localparam logic CFG_SPLIT = 1'b0;
	localparam logic CFG_SPREAD = 1'b1;
	localparam int QW = 26;

	// Divider job between the shaping stages.
	typedef struct packed {
		logic [49:0] num;
		logic [24:0] den;
	} tsrt_div_t;
endpackage
`default_nettype wire

@@ hw/rtl/tsrt_div.sv @@
// Pipelined rounding divider, one quotient bit per stage, quotient saturated to 1.0.
// Depends on tsrt_pkg.
`default_nettype none
module tsrt_div #(
	parameter int TW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire tsrt_pkg::tsrt_div_t  in_job,
	input  wire logic [TW-1:0]        in_tag,
	output logic                      out_valid,
	output logic [24:0]               out_quot,
	output logic [TW-1:0]             out_tag
);
	import tsrt_pkg::*;
	localparam int N = QW;

	logic [N:0]     vld_s;
	logic [51:0]    rem_s [N+1];
	logic [24:0]    den_s [N+1];
	logic [N-1:0]   q_s   [N+1];
	logic [TW-1:0]  tag_s [N+1];

	// Stage zero adds the half divisor for round-half-up.
	always_comb begin
		rem_s[0] = {2'b00, in_job.num} + {28'd0, in_job.den[24:1]};
		den_s[0] = in_job.den;
		q_s[0] = '0;
		tag_s[0] = in_tag;
	end
	assign vld_s[0] = in_valid;

	// Restoring division, MSB first, one bit each stage.
	for (genvar i = 0; i < N; i++) begin : g_st
		logic [51:0] tr;
		logic [51:0] sub;
		logic ge;
		assign tr = {26'd0, den_s[i]} << (N - 1 - i);
		assign ge = rem_s[i] >= tr;
		assign sub = rem_s[i] - tr;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? sub : rem_s[i];
				den_s[i+1] <= den_s[i];
				q_s[i+1] <= q_s[i] | (N'(ge) << (N - 1 - i));
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_quot = (q_s[N] > N'(IONE)) ? IONE : q_s[N][24:0];
	assign out_tag = tag_s[N];
endmodule
`default_nettype wire

@@ hw/rtl/two_segment_rational_taper_core.sv @@
// Two-segment rational taper core.
// Throughput one item per cycle; the whole pipe stalls when the output register
// is held. Two dividers of 26 stages each set the depth. Reset clears all valid
// bits and loads split_point = 1/2, spread_knob = 0. Depends on tsrt_pkg and
// tsrt_div.
`default_nettype none
module two_segment_rational_taper_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] time_value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] shaped_value
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import tsrt_pkg::*;
	localparam logic [16:0] QONE = 17'(1) << FRAC_BITS;
	localparam int SH = IFR - FRAC_BITS;
	// Tag through the dividers: clamped split, bypass flag, upper flag, sp, w.
	localparam int TW = 17 + 2 + 24 + 17;

	logic [15:0] split_q, spread_q;
	logic en;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 16'd16384;
			spread_q <= 16'd0;
		end else if (cfg_valid) begin
			case (cfg_index[0])
				CFG_SPLIT: split_q <= cfg_data;
				CFG_SPREAD: spread_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [16:0] xs, kc;
	assign xs = ({1'b0, split_q} > QONE) ? QONE : {1'b0, split_q};
	assign kc = ({1'b0, spread_q} > QONE) ? QONE : {1'b0, spread_q};

	// Output register and global enable.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: capture input, knob square.
	logic v_s1, byp_s1, up_s1;
	logic [16:0] t_s1, xs_s1;
	logic [24:0] k2_s1;
	logic [49:0] kk;
	logic [24:0] k24;
	assign k24 = 25'(kc) << SH;
	assign kk = k24 * k24;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= {1'b0, s_tdata};
			xs_s1 <= xs;
			byp_s1 <= {1'b0, s_tdata} >= QONE;
			up_s1 <= {1'b0, s_tdata} >= xs;
			k2_s1 <= 25'((kk + 50'(IONE >> 1)) >> IFR);
		end
	end

	// Stage 2: spread value and first division job.
	logic v_s2, byp_s2, up_s2;
	logic [16:0] xs_s2, w_s2;
	logic [23:0] sp_s2;
	tsrt_div_t j1_s2;
	logic [48:0] sm;
	logic [16:0] w1, nn;
	assign sm = k2_s1 * SPR_SPAN;
	assign w1 = QONE - xs_s1;
	assign nn = up_s1 ? t_s1 - xs_s1 : t_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			byp_s2 <= byp_s1;
			up_s2 <= up_s1;
			xs_s2 <= xs_s1;
			w_s2 <= w1;
			sp_s2 <= SPR_TOP - 24'((sm + 49'(IONE >> 1)) >> IFR);
			j1_s2.num <= 50'(nn) << IFR;
			j1_s2.den <= (byp_s1 || (up_s1 ? w1 : xs_s1) == 17'd0) ? 25'd1
				: 25'(up_s1 ? w1 : xs_s1);
		end
	end

	// First divider: x.
	logic d1v;
	logic [24:0] x_d;
	logic [TW-1:0] t1_d;
	tsrt_div #(.TW(TW)) u_div1 (
		.clk, .arst_n, .en, .in_valid(v_s2), .in_job(j1_s2),
		.in_tag({xs_s2, byp_s2, up_s2, sp_s2, w_s2}),
		.out_valid(d1v), .out_quot(x_d), .out_tag(t1_d)
	);

	// Stage 3: products sp*(1-x) or sp*x, and (1-sp)*x.
	logic v_s3;
	logic [TW-1:0] t_s3;
	logic [24:0] x_s3, pa_s3, pb_s3;
	logic [23:0] sp1;
	logic [48:0] pa, pb;
	assign sp1 = t1_d[40:17];
	assign pa = sp1 * (t1_d[41] ? x_d : IONE - x_d);
	assign pb = (IONE - 25'(sp1)) * x_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= d1v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= t1_d;
			x_s3 <= x_d;
			pa_s3 <= 25'((pa + 49'(IONE >> 1)) >> IFR);
			pb_s3 <= 25'((50'(pb) + 50'(IONE >> 1)) >> IFR);
		end
	end

	// Stage 4: second division job.
	logic v_s4;
	logic [TW-1:0] t_s4;
	tsrt_div_t j2_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s4 <= t_s3;
			j2_s4.num <= 50'(t_s3[41] ? pb_s3 : x_s3) << IFR;
			j2_s4.den <= (IONE - pa_s3 == 25'd0) ? 25'd1 : IONE - pa_s3;
		end
	end

	// Second divider: f.
	logic d2v;
	logic [24:0] f_d;
	logic [TW-1:0] t2_d;
	tsrt_div #(.TW(TW)) u_div2 (
		.clk, .arst_n, .en, .in_valid(v_s4), .in_job(j2_s4), .in_tag(t_s4),
		.out_valid(d2v), .out_quot(f_d), .out_tag(t2_d)
	);

	// Stage 5: scale f into its segment.
	logic v_s5;
	logic [TW-1:0] t_s5;
	logic [41:0] rp;
	logic [16:0] sc;
	logic [16:0] rs_s5;
	assign sc = t2_d[41] ? t2_d[16:0] : t2_d[59:43];
	assign rp = sc * f_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= d2v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s5 <= t2_d;
			rs_s5 <= 17'((rp + 42'(IONE >> 1)) >> IFR);
		end
	end

	// Output register: offset, saturation and bypass.
	logic [17:0] r;
	assign r = t_s5[41] ? 18'(t_s5[59:43]) + 18'(rs_s5) : 18'(rs_s5);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= (t_s5[42] || r > 18'(QONE)) ? QONE[15:0] : r[15:0];
		end
	end
endmodule
`default_nettype wire
